// ===== sv/f2fx_pkg.sv =====
// shared types and constants for the float to fixed point converter
package f2fx_pkg;

    localparam logic [7:0]  ExpMax    = 8'd255;
    localparam logic [7:0]  ExpBias   = 8'd127;

    typedef enum logic [1:0] {
        ST_NORMAL   = 2'd0,
        ST_INF      = 2'd1,
        ST_NAN      = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic {
        CFG_TOTAL_WIDTH   = 1'b0,
        CFG_FRACTION_BITS = 1'b1
    } cfg_index_t;

    // classification result passed from the decode stage to the shift stage
    typedef struct packed {
        logic        neg;
        logic [5:0]  win_shift;   // right shift of sig<<32 window, see shift stage
        logic [23:0] sig;
        logic        done;        // value already settled by a special case
        logic [31:0] fixed_value;
        status_t     status;
    } dec_t;

    typedef struct packed {
        logic        neg;
        logic        done;
        logic [31:0] mag;
        logic [31:0] fixed_value;
        status_t     status;
    } shf_t;

endpackage

// ===== sv/f2fx_stream_if.sv =====
// valid/ready channel interfaces for input and result items
interface f2fx_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] float_bits;
    modport source (output valid, output float_bits, input ready);
    modport sink   (input valid, input float_bits, output ready);
endinterface

interface f2fx_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] fixed_value;
    logic [1:0]  status;
    modport source (output valid, output fixed_value, output status, input ready);
    modport sink   (input valid, input fixed_value, input status, output ready);
endinterface

// ===== sv/f2fx_decode.sv =====
// stage 1 logic: field split, special cases, shift amount
module f2fx_decode
    import f2fx_pkg::*;
(
    input  logic [31:0] float_bits,
    input  logic [5:0]  total_width,
    input  logic [4:0]  fraction_bits,
    output dec_t        dec
);
    logic [5:0]  w;
    logic [7:0]  e;
    logic [22:0] m;
    logic [5:0]  int_bits;
    logic [9:0]  k;       // e - 150 + p, signed
    logic [31:0] top;

    always_comb
    begin
        w        = (total_width > 6'd32) ? 6'd32 : total_width;
        e        = float_bits[30:23];
        m        = float_bits[22:0];
        int_bits = (e < ExpBias) ? 6'd0 : 6'((e - 8'd126) > 8'd63 ? 8'd63 : (e - 8'd126));
        k        = 10'({2'b00, e}) - 10'd150 + 10'({5'd0, fraction_bits});
        top      = 32'hFFFF_FFFF >> (6'd33 - w);
        dec.neg  = float_bits[31];
        dec.sig  = {1'b1, m};
        // mag = (sig << 32 >> (32 - k)) low 32 bits; k in [-149,8] when in range
        // below -31 the shift would not fit, and the window is empty anyway
        if ($signed(k) < -10'sd31)
            dec.win_shift = 6'd63;
        else
            dec.win_shift = 6'(10'd32 - k);
        dec.done        = 1'b1;
        dec.fixed_value = '0;
        dec.status      = ST_NORMAL;
        if ({1'b0, fraction_bits} >= w)
        begin
            dec.fixed_value = '1;
            dec.status      = ST_OVERFLOW;
        end
        else if (e == 8'd0)
        begin
            dec.fixed_value = '0;
        end
        else if (e == ExpMax)
        begin
            if (m != '0)
                dec.status = ST_NAN;
            else
            begin
                dec.status      = ST_INF;
                dec.fixed_value = float_bits[31] ? ~top : top;
            end
        end
        else if (int_bits > (w - {1'b0, fraction_bits}))
        begin
            dec.fixed_value = '1;
            dec.status      = ST_OVERFLOW;
        end
        else
            dec.done = 1'b0;
    end
endmodule

// ===== sv/f2fx_shift.sv =====
// stage 2 logic: barrel shift of the significand into place
module f2fx_shift
    import f2fx_pkg::*;
(
    input  dec_t dec,
    output shf_t shf
);
    logic [55:0] win;
    always_comb
    begin
        win             = {dec.sig, 32'd0} >> dec.win_shift;
        shf.neg         = dec.neg;
        shf.done        = dec.done;
        shf.mag         = win[31:0];
        shf.fixed_value = dec.fixed_value;
        shf.status      = dec.status;
    end
endmodule

// ===== sv/float32_to_fixed_point.sv =====
// top level: three stage float32 to fixed point converter
//  channel   dir  handshake     payload
//  in_ch     in   valid/ready   float_bits[31:0]
//  out_ch    out  valid/ready   fixed_value[31:0], status[1:0]
//  cfg       in   cfg_we        cfg_index, cfg_wdata[5:0]
// one item per cycle sustained while out_ch.ready stays high; each item passes dec_reg, shf_reg, val_reg
// stages: decode and classify, barrel shift, negate into output register
// stall freezes every stage whose successor is full and frozen; nothing lost or repeated
// reset clears valid bits and sets width 32, fraction bits 16
module float32_to_fixed_point
    import f2fx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [5:0] cfg_wdata,
    f2fx_in_if.sink    in_ch,
    f2fx_out_if.source out_ch
);
    logic [5:0] width_reg;
    logic [4:0] frac_reg;
    logic       v1_reg, v2_reg, v3_reg;
    dec_t       dec_next, dec_reg;
    shf_t       shf_next, shf_reg;
    logic [31:0] val_reg, val_next;
    status_t    st_reg;
    logic       adv1, adv2, adv3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= 6'd32;
            frac_reg  <= 5'd16;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_TOTAL_WIDTH:   width_reg <= cfg_wdata;
                CFG_FRACTION_BITS: frac_reg  <= cfg_wdata[4:0];
                default:           width_reg <= width_reg;
            endcase
        end
    end

    assign adv3         = !v3_reg || out_ch.ready;
    assign adv2         = !v2_reg || adv3;
    assign adv1         = !v1_reg || adv2;
    assign in_ch.ready  = adv1;

    f2fx_decode u_dec (
        .float_bits    (in_ch.float_bits),
        .total_width   (width_reg),
        .fraction_bits (frac_reg),
        .dec           (dec_next)
    );

    f2fx_shift u_shf (
        .dec (dec_reg),
        .shf (shf_next)
    );

    always_comb
    begin
        if (shf_reg.done)
            val_next = shf_reg.fixed_value;
        else if (shf_reg.neg)
            val_next = 32'd0 - shf_reg.mag;
        else
            val_next = shf_reg.mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= in_ch.valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1) dec_reg <= dec_next;
        if (adv2) shf_reg <= shf_next;
        if (adv3)
        begin
            val_reg <= val_next;
            st_reg  <= shf_reg.status;
        end
    end

    assign out_ch.valid       = v3_reg;
    assign out_ch.fixed_value = val_reg;
    assign out_ch.status      = st_reg;

`ifndef NO_ASSERTIONS
    // a stalled result keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.fixed_value))
        else $error("result changed under stall");
    // overflow status always comes with all ones
    a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.status == ST_OVERFLOW |-> out_ch.fixed_value == '1)
        else $error("overflow without all ones");
    // nan gives zero
    a_nan: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.status == ST_NAN |-> out_ch.fixed_value == '0)
        else $error("nan not zero");
`endif
endmodule

// ===== bench/tb_float32_to_fixed_point.sv =====
// testbench for the float32 to fixed point converter: prediction, checking, stimulus
module tb_float32_to_fixed_point;
    import f2fx_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    class fixed_conv_board;
        logic [5:0]  width_reg;
        logic [4:0]  frac_reg;
        logic [31:0] exp_value_q[$];
        status_t     exp_status_q[$];
        int          errors;

        function new();
            width_reg = 6'd32;
            frac_reg  = 5'd16;
            errors    = 0;
        endfunction

        function void note_float(logic [31:0] f);
            int unsigned w;
            int unsigned p;
            int unsigned e;
            int unsigned ib;
            int          k;
            logic [22:0] m;
            logic        neg;
            logic [63:0] sig;
            logic [63:0] mag;
            logic [31:0] v;
            status_t     st;
            w   = (width_reg > 32) ? 32 : width_reg;
            p   = frac_reg;
            e   = f[30:23];
            m   = f[22:0];
            neg = f[31];
            v   = '0;
            st  = ST_NORMAL;
            if (p >= w)
            begin
                v  = '1;
                st = ST_OVERFLOW;
            end
            else if (e == 0)
            begin
                v = '0;
            end
            else if (e == ExpMax)
            begin
                if (m != 0)
                begin
                    st = ST_NAN;
                end
                else
                begin
                    v  = neg ? (32'hFFFF_FFFF << (w - 1)) : ((32'd1 << (w - 1)) - 32'd1);
                    st = ST_INF;
                end
            end
            else
            begin
                ib = (e < ExpBias) ? 0 : e - 126;
                if (ib > w - p)
                begin
                    v  = '1;
                    st = ST_OVERFLOW;
                end
                else
                begin
                    sig = {40'd0, 1'b1, m};
                    k   = int'(e) - 150 + int'(p);
                    if (k >= 0)
                        mag = sig << k;
                    else if (-k >= 64)
                        mag = '0;
                    else
                        mag = sig >> (-k);
                    v = mag[31:0];
                    if (neg)
                        v = 32'd0 - v;
                end
            end
            exp_value_q.push_back(v);
            exp_status_q.push_back(st);
        endfunction

        function void check_result(logic [31:0] v, logic [1:0] st);
            if (exp_value_q.size() == 0)
            begin
                $error("unexpected result fixed_value=%h status=%0d", v, st);
                errors++;
                return;
            end
            if (v !== exp_value_q[0])
            begin
                $error("fixed_value expected %h actual %h", exp_value_q[0], v);
                errors++;
            end
            if (st !== exp_status_q[0])
            begin
                $error("status expected %0d actual %0d", exp_status_q[0], st);
                errors++;
            end
            void'(exp_value_q.pop_front());
            void'(exp_status_q.pop_front());
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic [5:0] cfg_wdata;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_go = 1'b0;
    bit holding;
    longint cycle_cnt;
    fixed_conv_board board;

    f2fx_in_if  in_ch ();
    f2fx_out_if out_ch ();

    float32_to_fixed_point u_top (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .in_ch(in_ch), .out_ch(out_ch)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    initial
    begin
        board         = new();
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_TOTAL_WIDTH;
        cfg_wdata     = '0;
        in_ch.valid   = 1'b0;
        in_ch.float_bits = '0;
        out_ch.ready  = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
    end

    // long receiver hold-off, counted here once requested
    initial
    begin
        holding = 1'b0;
        wait (hold_go);
        @(posedge clk);
        holding <= 1'b1;
        repeat (60) @(posedge clk);
        holding <= 1'b0;
    end

    // receiver: random stall, held off while the long hold-off runs
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
                board.check_result(out_ch.fixed_value, out_ch.status);
            if (holding)
                out_ch.ready <= 1'b0;
            else
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= (rst_n === 1'b0) ? 0 : cycle_cnt + 1;
        if (cycle_cnt > 400000)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(cfg_index_t idx, logic [5:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_TOTAL_WIDTH)
            board.width_reg = val;
        else
            board.frac_reg = val[4:0];
    endtask

    task automatic send_float(logic [31:0] f);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.float_bits <= f;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        board.note_float(f);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (board.exp_value_q.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_float(int unsigned w, int unsigned p);
        logic [31:0] f;
        int unsigned lo;
        f = $urandom();
        case ($urandom_range(9))
            0: f[30:23] = 8'd0;
            1: f[30:23] = 8'd255;
            2: f[30:23] = 8'($urandom_range(255));
            default:
            begin
                // exponents near the overflow boundary and the fraction cutoff
                lo = (127 > p + 30) ? 127 - p - 30 : 1;
                f[30:23] = 8'($urandom_range(lo,
                    (127 + w - p + 1 > 254) ? 254 : 127 + w - p + 1));
            end
        endcase
        return f;
    endfunction

    initial
    begin
        logic [31:0] directed[$];
        int unsigned wv;
        int unsigned pv;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h807F_FFFF,
                     32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF,
                     32'h3F80_0000, 32'hBF80_0000, 32'h3F00_0000, 32'hBFC0_0000,
                     32'h4700_0000, 32'h46FF_FE00, 32'hC700_0000, 32'h7F7F_FFFF,
                     32'h0080_0000, 32'h3380_0000, 32'h42F6_E979, 32'hC2F6_E979};
        send_idle_pct = 24;
        recv_idle_pct = 57;
        foreach (directed[i])
            send_float(directed[i]);
        drain();

        // extremes: full width with no or maximal fraction, minimal width, fraction at width
        for (int s = 0; s < 5; s++)
        begin
            case (s)
                0:
                begin
                    wv = 32;
                    pv = 0;
                end
                1:
                begin
                    wv = 32;
                    pv = 31;
                end
                2:
                begin
                    wv = 2;
                    pv = 0;
                end
                3:
                begin
                    wv = 2;
                    pv = 1;
                end
                default:
                begin
                    wv = 8;
                    pv = 8;
                end
            endcase
            write_reg(CFG_TOTAL_WIDTH, wv[5:0]);
            write_reg(CFG_FRACTION_BITS, pv[5:0]);
            foreach (directed[i])
                if (i % 3 == s % 3 || i < 8)
                    send_float(directed[i]);
            drain();
        end

        for (int ph = 0; ph < 12; ph++)
        begin
            if (ph == 4)
            begin
                send_idle_pct = 57;
                recv_idle_pct = 24;
            end
            else if (ph == 8)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (ph % 4)
                0: wv = $urandom_range(2, 32);
                1: wv = $urandom_range(33, 63);
                2: wv = $urandom_range(0, 1);
                default: wv = 32;
            endcase
            pv = (wv > 1 && wv <= 32 && ph % 4 != 3) ? $urandom_range(0, wv - 1)
                                                      : $urandom_range(0, 31);
            write_reg(CFG_TOTAL_WIDTH, wv[5:0]);
            write_reg(CFG_FRACTION_BITS, pv[5:0]);
            if (ph == 10)
                hold_go = 1'b1;
            for (int n = 0; n < 50; n++)
                send_float(rand_float((wv > 32) ? 32 : wv, pv));
            drain();
        end

        if (board.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
